FILE: hw/rtl/fpcu_pkg.sv
package fpcu_pkg;

	localparam int SINE_ENTRIES_DEFAULT = 1024;

	localparam int FULL_TURN     = 46080;
	localparam int PITCH_LIMIT   = 11520;
	localparam int SPRINT_FACTOR = 3;

	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LOOK_SENS  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_SPEED = 4'd1;

	localparam logic [7:0]  SENS_RESET  = 8'd13;
	localparam logic [15:0] SPEED_RESET = 16'd6554;

	localparam logic signed [31:0] X_RESET = 32'sd32768;
	localparam logic signed [31:0] Z_RESET = 32'sd1310720;

	typedef enum logic {
		CMD_LOOK = 1'b0,
		CMD_MOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_FORWARD = 2'd0,
		DIR_BACK    = 2'd1,
		DIR_LEFT    = 2'd2,
		DIR_RIGHT   = 2'd3
	} dir_t;

	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
		logic ld_out;
	} pipe_ctl_t;

	// Sine of a Q30 angle in [0, 2*pi), returned in Q16, by a Taylor series to x^13.
	function automatic logic signed [17:0] sine_q16(input logic [63:0] ang);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic neg;
		a = ang;
		neg = 1'b0;
		if (a >= PI_Q30) begin
			neg = 1'b1;
			a = a - PI_Q30;
		end
		if (a > HALF_PI_Q30) begin
			a = PI_Q30 - a;
		end
		x2 = (a * a) >> 30;
		term = a;
		sum = $signed(a);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		sum = (sum + 64'sd8192) >>> 14;
		if (sum > 64'sd65536) begin
			sum = 64'sd65536;
		end
		return neg ? -18'(sum) : 18'(sum);
	endfunction

endpackage

FILE: hw/rtl/fps_camera_pose_update_unit.sv
// An accepted item passes through stages s1 to s4 and then the output register.
// Throughput: one item per cycle while the output is taken; the path that sets the
// cycle is the heading index multiply and the registered sine table read from yaw_q.
// Reset is asynchronous and active low: the pipeline empties, the pose returns
// to pitch 0, yaw 0, x 0.5, z 20.0, and the registers to 13 and 6554.
module fps_camera_pose_update_unit #(
	parameter int SINE_TABLE_ENTRIES = fpcu_pkg::SINE_ENTRIES_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic signed [8:0]                     mouse_dx,
	input  logic signed [8:0]                     mouse_dy,
	input  logic [1:0]                            move_dir,
	input  logic                                  sprint,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [14:0]                    pitch_angle,
	output logic [15:0]                           yaw_angle,
	output logic signed [31:0]                    pos_x,
	output logic signed [31:0]                    pos_z,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fpcu_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fpcu_pkg::CFG_DATA_W-1:0]       cfg_data
);

	fpcu_pkg::pipe_ctl_t ctl;

	logic [7:0]  sens_q;
	logic [15:0] speed_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic out_valid_q;
	logic in_acc;
	logic out_take;

	fpcu_pkg::cmd_t     cmd_s1;
	logic signed [8:0]  dx_s1;
	logic signed [8:0]  dy_s1;
	fpcu_pkg::dir_t     dir_s1;
	logic               sprint_s1;
	logic               is_look;
	logic [17:0]        speed_eff;

	logic [15:0]        yaw_q;
	logic signed [14:0] pitch_nx;
	logic [15:0]        yaw_nx;

	logic signed [14:0] pitch_s2;
	logic [15:0]        yaw_s2;
	fpcu_pkg::dir_t     dir_s2;
	logic [17:0]        speed_s2;
	logic signed [17:0] sin_s2;
	logic signed [17:0] cos_s2;
	logic signed [14:0] pitch_s3;
	logic [15:0]        yaw_s3;
	logic signed [14:0] pitch_s4;
	logic [15:0]        yaw_s4;
	logic signed [19:0] step_x_s4;
	logic signed [19:0] step_z_s4;
	logic signed [14:0] out_pitch_q;
	logic [15:0]        out_yaw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= fpcu_pkg::SENS_RESET;
			speed_q <= fpcu_pkg::SPEED_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fpcu_pkg::REG_LOOK_SENS:  sens_q  <= cfg_data[7:0];
				fpcu_pkg::REG_STEP_SPEED: speed_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		out_take   = out_valid_q && out_ready;
		ctl.ld_out = v_s4 && (!out_valid_q || out_take);
		ctl.ld4    = v_s3 && (!v_s4 || ctl.ld_out);
		ctl.ld3    = v_s2 && (!v_s3 || ctl.ld4);
		ctl.ld2    = v_s1 && (!v_s2 || ctl.ld3);
		in_ready   = !v_s1 || ctl.ld2;
		in_acc     = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (ctl.ld2) begin
				v_s1 <= 1'b0;
			end
			if (ctl.ld2) begin
				v_s2 <= 1'b1;
			end else if (ctl.ld3) begin
				v_s2 <= 1'b0;
			end
			if (ctl.ld3) begin
				v_s3 <= 1'b1;
			end else if (ctl.ld4) begin
				v_s3 <= 1'b0;
			end
			if (ctl.ld4) begin
				v_s4 <= 1'b1;
			end else if (ctl.ld_out) begin
				v_s4 <= 1'b0;
			end
			if (ctl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= fpcu_pkg::cmd_t'(cmd);
			dx_s1     <= mouse_dx;
			dy_s1     <= mouse_dy;
			dir_s1    <= fpcu_pkg::dir_t'(move_dir);
			sprint_s1 <= sprint;
		end
	end

	// A look item carries zero speed, so its step is zero.
	always_comb begin
		is_look = (cmd_s1 == fpcu_pkg::CMD_LOOK);
		if (is_look) begin
			speed_eff = '0;
		end else if (sprint_s1) begin
			speed_eff = 18'(speed_q) * 18'(fpcu_pkg::SPRINT_FACTOR);
		end else begin
			speed_eff = 18'(speed_q);
		end
	end

	fpcu_look u_look (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ctl.ld2),
		.is_look  (is_look),
		.dx       (dx_s1),
		.dy       (dy_s1),
		.sens     (sens_q),
		.yaw_q    (yaw_q),
		.pitch_nx (pitch_nx),
		.yaw_nx   (yaw_nx)
	);

	fpcu_heading #(
		.SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
	) u_heading (
		.clk    (clk),
		.load   (ctl.ld2),
		.yaw    (yaw_q),
		.sin_s2 (sin_s2),
		.cos_s2 (cos_s2)
	);

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			pitch_s2 <= pitch_nx;
			yaw_s2   <= yaw_nx;
			dir_s2   <= dir_s1;
			speed_s2 <= speed_eff;
		end
		if (ctl.ld3) begin
			pitch_s3 <= pitch_s2;
			yaw_s3   <= yaw_s2;
		end
		if (ctl.ld4) begin
			pitch_s4 <= pitch_s3;
			yaw_s4   <= yaw_s3;
		end
		if (ctl.ld_out) begin
			out_pitch_q <= pitch_s4;
			out_yaw_q   <= yaw_s4;
		end
	end

	fpcu_step u_step (
		.clk       (clk),
		.ctl       (ctl),
		.sin_s2    (sin_s2),
		.cos_s2    (cos_s2),
		.dir_s2    (dir_s2),
		.speed_s2  (speed_s2),
		.step_x_s4 (step_x_s4),
		.step_z_s4 (step_z_s4)
	);

	fpcu_position u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.step_x_s4 (step_x_s4),
		.step_z_s4 (step_z_s4),
		.x_q       (pos_x),
		.z_q       (pos_z)
	);

	assign out_valid   = out_valid_q;
	assign pitch_angle = out_pitch_q;
	assign yaw_angle   = out_yaw_q;

`ifndef SYNTHESIS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && out_valid_q && !out_ready)
		else $error("Input stalled while the pipeline has room.");
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_angle <= 15'sd11520 && pitch_angle >= -15'sd11520
			&& yaw_angle < 16'd46080)
		else $error("Result angles out of range.");
`endif

endmodule

FILE: hw/rtl/fpcu_look.sv
module fpcu_look (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                is_look,
	input  logic signed [8:0]   dx,
	input  logic signed [8:0]   dy,
	input  logic [7:0]          sens,
	output logic [15:0]         yaw_q,
	output logic signed [14:0]  pitch_nx,
	output logic [15:0]         yaw_nx
);

	logic signed [14:0] pitch_q;
	logic signed [8:0]  sens_s;
	logic signed [17:0] dx_prod;
	logic signed [17:0] dy_prod;
	logic signed [18:0] p_sum;
	logic signed [14:0] pitch_new;
	logic signed [17:0] y_sum;
	logic signed [17:0] y_wrap;
	logic [15:0]        yaw_new;

	always_comb begin
		sens_s  = $signed({1'b0, sens});
		dx_prod = 18'(dx) * 18'(sens_s);
		dy_prod = 18'(dy) * 18'(sens_s);
		p_sum   = 19'(pitch_q) + 19'(dy_prod);
		if (p_sum > 19'sd11520) begin
			pitch_new = 15'(fpcu_pkg::PITCH_LIMIT);
		end else if (p_sum < -19'sd11520) begin
			pitch_new = -15'(fpcu_pkg::PITCH_LIMIT);
		end else begin
			pitch_new = 15'(p_sum);
		end
		y_sum = $signed({2'b00, yaw_q}) + dx_prod;
		if (y_sum < -18'sd46080) begin
			y_wrap = y_sum + 18'sd92160;
		end else if (y_sum < 18'sd0) begin
			y_wrap = y_sum + 18'sd46080;
		end else if (y_sum >= 18'sd92160) begin
			y_wrap = y_sum - 18'sd92160;
		end else if (y_sum >= 18'sd46080) begin
			y_wrap = y_sum - 18'sd46080;
		end else begin
			y_wrap = y_sum;
		end
		yaw_new  = 16'(y_wrap);
		pitch_nx = is_look ? pitch_new : pitch_q;
		yaw_nx   = is_look ? yaw_new : yaw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			yaw_q   <= '0;
		end else if (load && is_look) begin
			pitch_q <= pitch_new;
			yaw_q   <= yaw_new;
		end
	end

endmodule

FILE: hw/rtl/fpcu_heading.sv
module fpcu_heading #(
	parameter int SINE_TABLE_ENTRIES = fpcu_pkg::SINE_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               load,
	input  logic [15:0]        yaw,
	output logic signed [17:0] sin_s2,
	output logic signed [17:0] cos_s2
);

	localparam int IDXW = $clog2(SINE_TABLE_ENTRIES);
	localparam logic [63:0] IDX_MUL =
		((64'(SINE_TABLE_ENTRIES) << 31) + 64'(fpcu_pkg::FULL_TURN) - 64'd1) /
		64'(fpcu_pkg::FULL_TURN);
	localparam logic [IDXW:0] QUARTER = (IDXW + 1)'(SINE_TABLE_ENTRIES / 4);
	localparam logic [IDXW:0] ENTRIES = (IDXW + 1)'(SINE_TABLE_ENTRIES);

	logic signed [17:0] sine_rom [SINE_TABLE_ENTRIES];
	logic [47:0]        idx_prod;
	logic [IDXW-1:0]    sin_idx;
	logic [IDXW:0]      cos_sum;
	logic [IDXW-1:0]    cos_idx;

	for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_rom
		localparam logic [63:0] ANG =
			(64'(g) * fpcu_pkg::TWO_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
		assign sine_rom[g] = fpcu_pkg::sine_q16(ANG);
	end

	// The reciprocal is exact for every yaw below one full turn.
	always_comb begin
		idx_prod = 48'(yaw) * IDX_MUL[47:0];
		sin_idx  = idx_prod[31 +: IDXW];
		cos_sum  = {1'b0, sin_idx} + QUARTER;
		if (cos_sum >= ENTRIES) begin
			cos_idx = IDXW'(cos_sum - ENTRIES);
		end else begin
			cos_idx = IDXW'(cos_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sin_s2 <= sine_rom[sin_idx];
			cos_s2 <= sine_rom[cos_idx];
		end
	end

endmodule

FILE: hw/rtl/fpcu_step.sv
module fpcu_step (
	input  logic                  clk,
	input  fpcu_pkg::pipe_ctl_t   ctl,
	input  logic signed [17:0]    sin_s2,
	input  logic signed [17:0]    cos_s2,
	input  fpcu_pkg::dir_t        dir_s2,
	input  logic [17:0]           speed_s2,
	output logic signed [19:0]    step_x_s4,
	output logic signed [19:0]    step_z_s4
);

	logic signed [17:0] vx;
	logic signed [17:0] vz;
	logic signed [18:0] speed_s;
	logic signed [36:0] px;
	logic signed [36:0] pz;
	logic signed [36:0] px_s3;
	logic signed [36:0] pz_s3;
	logic signed [36:0] rx;
	logic signed [36:0] rz;

	always_comb begin
		unique case (dir_s2)
			fpcu_pkg::DIR_FORWARD: begin
				vx = sin_s2;
				vz = -cos_s2;
			end
			fpcu_pkg::DIR_BACK: begin
				vx = -sin_s2;
				vz = cos_s2;
			end
			fpcu_pkg::DIR_LEFT: begin
				vx = -cos_s2;
				vz = -sin_s2;
			end
			fpcu_pkg::DIR_RIGHT: begin
				vx = cos_s2;
				vz = sin_s2;
			end
			default: begin
				vx = '0;
				vz = '0;
			end
		endcase
		speed_s = $signed({1'b0, speed_s2});
		px = 37'(vx) * 37'(speed_s);
		pz = 37'(vz) * 37'(speed_s);
	end

	// Round to nearest with ties away from zero.
	always_comb begin
		rx = px_s3 + (px_s3[36] ? 37'sd32767 : 37'sd32768);
		rz = pz_s3 + (pz_s3[36] ? 37'sd32767 : 37'sd32768);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			px_s3 <= px;
			pz_s3 <= pz;
		end
		if (ctl.ld4) begin
			step_x_s4 <= 20'(rx >>> 16);
			step_z_s4 <= 20'(rz >>> 16);
		end
	end

endmodule

FILE: hw/rtl/fpcu_position.sv
module fpcu_position (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpcu_pkg::pipe_ctl_t   ctl,
	input  logic signed [19:0]    step_x_s4,
	input  logic signed [19:0]    step_z_s4,
	output logic signed [31:0]    x_q,
	output logic signed [31:0]    z_q
);

	logic signed [32:0] x_sum;
	logic signed [32:0] z_sum;
	logic signed [31:0] x_new;
	logic signed [31:0] z_new;

	always_comb begin
		x_sum = 33'(x_q) + 33'(step_x_s4);
		z_sum = 33'(z_q) + 33'(step_z_s4);
		if (x_sum[32] != x_sum[31]) begin
			x_new = x_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			x_new = x_sum[31:0];
		end
		if (z_sum[32] != z_sum[31]) begin
			z_new = z_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			z_new = z_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= fpcu_pkg::X_RESET;
			z_q <= fpcu_pkg::Z_RESET;
		end else if (ctl.ld_out) begin
			x_q <= x_new;
			z_q <= z_new;
		end
	end

`ifndef SYNTHESIS
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.ld_out |=> $stable(x_q) && $stable(z_q))
		else $error("Position changed without an item leaving the last stage.");
`endif

endmodule
